/* hw/rtl/tct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_pkg: shared types and constants for the touch contact table
// command and phase codes, table geometry, entry and beat structures
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int MAX_CONTACTS = 16;
    localparam int IDX_W        = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);
    localparam int QIDX_W       = 4;
    localparam int QCMP_W       = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;
    localparam int ACT_W        = 5;

    typedef logic [2:0] cmd_t;
    typedef logic [1:0] phase_t;

    localparam cmd_t CMD_DOWN  = 3'd0;
    localparam cmd_t CMD_MOVE  = 3'd1;
    localparam cmd_t CMD_UP    = 3'd2;
    localparam cmd_t CMD_FLUSH = 3'd3;
    localparam cmd_t CMD_QUERY = 3'd4;

    localparam phase_t PH_BEGIN = 2'd0;
    localparam phase_t PH_MOVE  = 2'd1;
    localparam phase_t PH_END   = 2'd2;

    typedef struct packed {
        logic [31:0]        ident;
        logic signed [15:0] x;
        logic signed [15:0] y;
        phase_t             phase;
    } entry_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [31:0]        touch_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [QIDX_W-1:0]  query_index;
    } req_t;

    typedef struct packed {
        logic [ACT_W-1:0]   active_count;
        logic               found;
        logic [31:0]        out_id;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        phase_t             out_phase;
        logic               overflow;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] active;
    } status_t;

endpackage

/* hw/rtl/tct_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_in_if: touch event channel
// valid/ready channel carrying one touch command per beat
// ----------------------------------------------------------------------------
interface tct_in_if;
    logic                       valid;
    logic                       ready;
    tct_pkg::cmd_t              cmd;
    logic [31:0]                touch_id;
    logic signed [15:0]         pos_x;
    logic signed [15:0]         pos_y;
    logic [tct_pkg::QIDX_W-1:0] query_index;

    modport source (output valid, cmd, touch_id, pos_x, pos_y, query_index, input ready);
    modport sink   (input valid, cmd, touch_id, pos_x, pos_y, query_index, output ready);
endinterface

/* hw/rtl/tct_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_out_if: result channel
// valid/ready channel carrying one table result per beat
// ----------------------------------------------------------------------------
interface tct_out_if;
    logic                      valid;
    logic                      ready;
    logic [tct_pkg::ACT_W-1:0] active_count;
    logic                      found;
    logic [31:0]               out_id;
    logic signed [15:0]        out_x;
    logic signed [15:0]        out_y;
    tct_pkg::phase_t           out_phase;
    logic                      overflow;

    modport source (output valid, active_count, found, out_id, out_x, out_y, out_phase,
                    overflow, input ready);
    modport sink   (input valid, active_count, found, out_id, out_x, out_y, out_phase,
                    overflow, output ready);
endinterface

/* hw/rtl/touch_contact_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_contact_table: ordered table of touch contacts
// down/move/up/end-of-frame/query commands over a walked entry store
// ----------------------------------------------------------------------------
// usage
//   evt carries one command per beat (down, move, up, end of frame, query);
//   res returns exactly one result beat per command, in order
//   a command is walked over the table one entry per cycle through a single
//   id/phase compare unit; the entry store gives registered read data, so
//   each entry is checked while the read of the next one is issued; the
//   beat is taken in idle and the result is handed off from the done state
//   move, up, down-reuse and query stop at the first hit, end of frame and a
//   fresh down always walk the whole used part of the table
//   evt.ready is high only while the sequencer waits for a command
//   the result sits in an output register; the next command is taken while
//   that beat waits for res.ready, and a second result holds in the sequencer
//   until the register frees up
//   reset clears the fill and active counts and all handshake state; entry
//   storage is not cleared, entries past the fill count are never read
// ----------------------------------------------------------------------------
module touch_contact_table (
    input  logic      clk,
    input  logic      rst_n,
    tct_in_if.sink    evt,
    tct_out_if.source res
);
    import tct_pkg::*;

    req_t    req;
    res_t    seq_res;
    logic    seq_res_valid;
    logic    seq_res_ready;
    mem_wr_t wr;
    mem_rd_t rd;
    entry_t  rd_data;
    status_t st;

    // output register
    logic out_vld_reg;
    res_t out_data_reg;

    assign req.cmd         = evt.cmd;
    assign req.touch_id    = evt.touch_id;
    assign req.pos_x       = evt.pos_x;
    assign req.pos_y       = evt.pos_y;
    assign req.query_index = evt.query_index;

    tct_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (evt.valid),
        .req_ready (evt.ready),
        .req       (req),
        .res_valid (seq_res_valid),
        .res_ready (seq_res_ready),
        .res       (seq_res),
        .wr        (wr),
        .rd        (rd),
        .rd_data   (rd_data),
        .st        (st)
    );

    tct_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // the register can take a new result when empty or draining this cycle
    assign seq_res_ready = !out_vld_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (seq_res_valid && seq_res_ready)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_res_valid && seq_res_ready)
        begin
            out_data_reg <= seq_res;
        end
    end

    assign res.valid        = out_vld_reg;
    assign res.active_count = out_data_reg.active_count;
    assign res.found        = out_data_reg.found;
    assign res.out_id       = out_data_reg.out_id;
    assign res.out_x        = out_data_reg.out_x;
    assign res.out_y        = out_data_reg.out_y;
    assign res.out_phase    = out_data_reg.out_phase;
    assign res.overflow     = out_data_reg.overflow;

    // active entries are a subset of the used entries
    a_active_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        st.active <= st.fill)
        else $error("active count exceeds fill count");

    // the fill count never runs past the table size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st.fill <= CNT_W'(MAX_CONTACTS))
        else $error("fill count beyond table size");

    // a taken command leaves the sequencer busy in the following cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && evt.ready) |=> (!evt.ready && !st.idle))
        else $error("command taken while sequencer still idle");

    // a dropped down never reports a reused entry
    a_overflow_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.found && res.overflow))
        else $error("found and overflow both set");

endmodule

/* hw/rtl/tct_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_mem: contact entry storage
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tct_mem (
    input  logic             clk,
    input  tct_pkg::mem_wr_t wr,
    input  tct_pkg::mem_rd_t rd,
    output tct_pkg::entry_t  rd_data
);
    import tct_pkg::*;

    entry_t mem [MAX_CONTACTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/tct_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_seq: table walk sequencer
// walks the entries one per cycle through a single id/phase compare unit
// ----------------------------------------------------------------------------
module tct_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  tct_pkg::req_t    req,
    output logic             res_valid,
    input  logic             res_ready,
    output tct_pkg::res_t    res,
    output tct_pkg::mem_wr_t wr,
    output tct_pkg::mem_rd_t rd,
    input  tct_pkg::entry_t  rd_data,
    output tct_pkg::status_t st
);
    import tct_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t           state_reg,  state_next;
    req_t             req_reg,    req_next;
    res_t             res_reg,    res_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic [CNT_W-1:0] active_reg, active_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] k_reg,      k_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             id_hit;
    logic             ended;

    assign id_hit = (rd_data.ident == req_reg.touch_id);
    assign ended  = (rd_data.phase == PH_END);

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        fill_next    = fill_reg;
        active_next  = active_reg;
        rd_ptr_next  = rd_ptr_reg;
        k_next       = k_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        wr           = '0;
        rd           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next     = req;
                    res_next     = '0;
                    rd_ptr_next  = '0;
                    k_next       = '0;
                    chk_vld_next = 1'b0;
                    if (req.cmd inside {CMD_DOWN, CMD_MOVE, CMD_UP, CMD_FLUSH, CMD_QUERY})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue the next read while the previous entry is checked
                if (rd_ptr_reg < fill_reg)
                begin
                    rd.en        = 1'b1;
                    rd.addr      = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_ptr_reg[IDX_W-1:0];
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                if (chk_vld_reg)
                begin
                    case (req_reg.cmd)
                        CMD_DOWN:
                        begin
                            if (id_hit && ended)
                            begin
                                wr.en          = 1'b1;
                                wr.addr        = chk_idx_reg;
                                wr.data        = {req_reg.touch_id, req_reg.pos_x,
                                                  req_reg.pos_y, PH_BEGIN};
                                res_next.found = 1'b1;
                                active_next    = active_reg + 1'b1;
                                state_next     = ST_DONE;
                            end
                        end
                        CMD_MOVE, CMD_UP:
                        begin
                            if (id_hit)
                            begin
                                wr.en          = 1'b1;
                                wr.addr        = chk_idx_reg;
                                wr.data        = {req_reg.touch_id, req_reg.pos_x,
                                                  req_reg.pos_y,
                                                  (req_reg.cmd == CMD_MOVE) ? PH_MOVE : PH_END};
                                res_next.found = 1'b1;
                                if (req_reg.cmd == CMD_MOVE && ended)
                                begin
                                    active_next = active_reg + 1'b1;
                                end
                                else if (req_reg.cmd == CMD_UP && !ended)
                                begin
                                    active_next = active_reg - 1'b1;
                                end
                                state_next = ST_DONE;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            // compact live entries toward the front
                            if (!ended)
                            begin
                                if (k_reg != CNT_W'(chk_idx_reg))
                                begin
                                    wr.en   = 1'b1;
                                    wr.addr = k_reg[IDX_W-1:0];
                                    wr.data = rd_data;
                                end
                                k_next = k_reg + 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (!ended)
                            begin
                                if (QCMP_W'(k_reg) == QCMP_W'(req_reg.query_index))
                                begin
                                    res_next.found     = 1'b1;
                                    res_next.out_id    = rd_data.ident;
                                    res_next.out_x     = rd_data.x;
                                    res_next.out_y     = rd_data.y;
                                    res_next.out_phase = rd_data.phase;
                                    state_next         = ST_DONE;
                                end
                                else
                                begin
                                    k_next = k_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (rd_ptr_reg >= fill_reg)
                begin
                    // walk finished without an early hit
                    case (req_reg.cmd)
                        CMD_DOWN:
                        begin
                            if (fill_reg < CNT_W'(MAX_CONTACTS))
                            begin
                                wr.en       = 1'b1;
                                wr.addr     = fill_reg[IDX_W-1:0];
                                wr.data     = {req_reg.touch_id, req_reg.pos_x,
                                               req_reg.pos_y, PH_BEGIN};
                                fill_next   = fill_reg + 1'b1;
                                active_next = active_reg + 1'b1;
                            end
                            else
                            begin
                                res_next.overflow = 1'b1;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            fill_next = k_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            active_reg  <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            active_reg  <= active_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        rd_ptr_reg  <= rd_ptr_next;
        k_reg       <= k_next;
        chk_idx_reg <= chk_idx_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res              = res_reg;
        res.active_count = ACT_W'(active_reg);
    end

    assign st.idle   = (state_reg == ST_IDLE);
    assign st.fill   = fill_reg;
    assign st.active = active_reg;

endmodule

/* test/tct_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_result_checker: contact table prediction and result compare
// mirrors the table on every accepted command beat and checks each result beat
// ----------------------------------------------------------------------------
module tct_result_checker
    import tct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tct_in_if    evt,
    tct_out_if   res,
    output int   fail_count,
    output int   results_owed
);

    localparam int REPORT_LIMIT = 10;

    entry_t contacts [MAX_CONTACTS];
    int     contacts_used = 0;
    res_t   expected_results [$];
    int     errors = 0;
    int     owed = 0;

    assign fail_count   = errors;
    assign results_owed = owed;

    // applies one command to the mirrored table and returns its result
    function automatic res_t apply_command(req_t rq);
        res_t r;
        int   i;
        int   k;
        int   n_act;
        r = '0;
        case (rq.cmd)
            CMD_DOWN:
            begin
                for (i = 0; i < contacts_used; i++)
                begin
                    if (contacts[i].ident == rq.touch_id && contacts[i].phase == PH_END)
                    begin
                        contacts[i] = '{rq.touch_id, rq.pos_x, rq.pos_y, PH_BEGIN};
                        r.found = 1'b1;
                        break;
                    end
                end
                if (!r.found)
                begin
                    if (contacts_used < MAX_CONTACTS)
                    begin
                        contacts[contacts_used] = '{rq.touch_id, rq.pos_x, rq.pos_y, PH_BEGIN};
                        contacts_used++;
                    end
                    else
                        r.overflow = 1'b1;
                end
            end
            CMD_MOVE, CMD_UP:
            begin
                for (i = 0; i < contacts_used; i++)
                begin
                    if (contacts[i].ident == rq.touch_id)
                    begin
                        contacts[i] = '{rq.touch_id, rq.pos_x, rq.pos_y,
                                        (rq.cmd == CMD_MOVE) ? PH_MOVE : PH_END};
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            CMD_FLUSH:
            begin
                k = 0;
                for (i = 0; i < contacts_used; i++)
                begin
                    if (contacts[i].phase != PH_END)
                    begin
                        contacts[k] = contacts[i];
                        k++;
                    end
                end
                contacts_used = k;
            end
            CMD_QUERY:
            begin
                k = 0;
                for (i = 0; i < contacts_used; i++)
                begin
                    if (contacts[i].phase != PH_END)
                    begin
                        if (k == int'(rq.query_index))
                        begin
                            r.found     = 1'b1;
                            r.out_id    = contacts[i].ident;
                            r.out_x     = contacts[i].x;
                            r.out_y     = contacts[i].y;
                            r.out_phase = contacts[i].phase;
                            break;
                        end
                        k++;
                    end
                end
            end
            default: ;
        endcase
        n_act = 0;
        for (i = 0; i < contacts_used; i++)
            if (contacts[i].phase != PH_END)
                n_act++;
        r.active_count = n_act[ACT_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        req_t rq;
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (evt.valid && evt.ready)
            begin
                rq.cmd         = evt.cmd;
                rq.touch_id    = evt.touch_id;
                rq.pos_x       = evt.pos_x;
                rq.pos_y       = evt.pos_y;
                rq.query_index = evt.query_index;
                expected_results = {expected_results, apply_command(rq)};
            end
            if (res.valid && res.ready)
            begin
                got.active_count = res.active_count;
                got.found        = res.found;
                got.out_id       = res.out_id;
                got.out_x        = res.out_x;
                got.out_y        = res.out_y;
                got.out_phase    = res.out_phase;
                got.overflow     = res.overflow;
                if (expected_results.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t: result beat with no command pending", $time);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.active_count !== want.active_count || got.found !== want.found
                        || got.out_id !== want.out_id || got.out_x !== want.out_x
                        || got.out_y !== want.out_y || got.out_phase !== want.out_phase
                        || got.overflow !== want.overflow)
                    begin
                        if (errors < REPORT_LIMIT)
                        begin
                            $display({"%0t: mismatch exp cnt=%0d fnd=%0b id=%h x=%0d y=%0d",
                                      " ph=%0d ovf=%0b"},
                                     $time, want.active_count, want.found, want.out_id,
                                     want.out_x, want.out_y, want.out_phase, want.overflow);
                            $display({"%0t:          got cnt=%0d fnd=%0b id=%h x=%0d y=%0d",
                                      " ph=%0d ovf=%0b"},
                                     $time, got.active_count, got.found, got.out_id,
                                     got.out_x, got.out_y, got.out_phase, got.overflow);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            owed <= expected_results.size();
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: touch contact table
// directed corner commands, then chunks of random traffic with growing,
// shrinking and mixed command mixes over small and large id pools; the
// sender idles in bursts, the receiver stalls on its own pattern
// ----------------------------------------------------------------------------
module testbench;
    import tct_pkg::*;

    // command codes the block ignores
    localparam cmd_t CMD_SPARE_LO = 3'd5;
    localparam cmd_t CMD_SPARE_HI = 3'd7;

    localparam int CHUNKS      = 19;
    localparam int CHUNK_BEATS = 100;
    localparam int POOL_SIZE   = 48;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;

    // two long receiver hold-offs, in cycles from time zero
    localparam int HOLD_A   = 2000;
    localparam int HOLD_B   = 20000;
    localparam int HOLD_LEN = 600;

    typedef enum int { TR_GROW, TR_SHRINK, TR_MIXED } traffic_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tct_in_if  evt_ch ();
    tct_out_if res_ch ();

    int fail_count;
    int results_owed;

    // sender burst state
    int burst_left = 0;
    logic steady = 1'b0;
    logic [31:0] id_pool [POOL_SIZE];

    // receiver state
    int rx_cycle = 0;
    int rx_mode = 0;
    logic rx_ready = 1'b0;

    int unsigned cycle_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    touch_contact_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch)
    );

    tct_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt_ch),
        .res          (res_ch),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // receiver: ready pattern is redrawn whenever the low bits of its cycle
    // counter roll over to zero, with two long hold-offs so the block fills up and drops evt ready
    assign res_ch.ready = rx_ready;

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[5:0] == 6'd0)
            rx_mode <= $urandom_range(0, 3);
        if ((rx_cycle >= HOLD_A && rx_cycle < HOLD_A + HOLD_LEN)
            || (rx_cycle >= HOLD_B && rx_cycle < HOLD_B + HOLD_LEN))
            rx_ready <= 1'b0;
        else
        begin
            case (rx_mode)
                0:       rx_ready <= 1'b1;
                1:       rx_ready <= 1'($urandom_range(0, 1));
                2:       rx_ready <= (rx_cycle % 3) != 0;
                default: rx_ready <= $urandom_range(0, 9) != 0;
            endcase
        end
    end

    // offers one command beat and returns at the edge that takes it;
    // gaps only open between bursts, and never in a steady stretch
    task automatic send_beat(input cmd_t c, input logic [31:0] id,
                             input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic [QIDX_W-1:0] q);
        int gap;
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                evt_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        evt_ch.valid       <= 1'b1;
        evt_ch.cmd         <= c;
        evt_ch.touch_id    <= id;
        evt_ch.pos_x       <= x;
        evt_ch.pos_y       <= y;
        evt_ch.query_index <= q;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // command mix per traffic kind; a small share goes to the ignored codes
    function automatic cmd_t pick_cmd(traffic_t kind);
        int roll;
        int w_down;
        int w_move;
        int w_up;
        int w_flush;
        int w_query;
        case (kind)
            TR_GROW:
            begin
                w_down = 50; w_move = 20; w_up = 10; w_flush = 5;  w_query = 13;
            end
            TR_SHRINK:
            begin
                w_down = 15; w_move = 15; w_up = 35; w_flush = 15; w_query = 18;
            end
            default:
            begin
                w_down = 30; w_move = 20; w_up = 20; w_flush = 10; w_query = 18;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < w_down)
            return CMD_DOWN;
        roll -= w_down;
        if (roll < w_move)
            return CMD_MOVE;
        roll -= w_move;
        if (roll < w_up)
            return CMD_UP;
        roll -= w_up;
        if (roll < w_flush)
            return CMD_FLUSH;
        roll -= w_flush;
        if (roll < w_query)
            return CMD_QUERY;
        return cmd_t'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    endfunction

    // mostly ids from the pool so commands hit; the rest are random misses
    function automatic logic [31:0] pick_id(int pool_used);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return id_pool[$urandom_range(0, pool_used - 1)];
    endfunction

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int k;
        int chunk;
        int n;
        int pool_used;
        traffic_t kind;
        logic [QIDX_W-1:0] q;

        evt_ch.valid       <= 1'b0;
        evt_ch.cmd         <= CMD_QUERY;
        evt_ch.touch_id    <= '0;
        evt_ch.pos_x       <= '0;
        evt_ch.pos_y       <= '0;
        evt_ch.query_index <= '0;

        // pool holds the id extremes plus random ids
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        id_pool[2] = 32'h8000_0000;
        for (k = 3; k < POOL_SIZE; k++)
            id_pool[k] = $urandom;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table query, unknown id, ignored codes
        send_beat(CMD_QUERY, 32'h0, 16'sh0, 16'sh0, 4'd0);
        send_beat(CMD_MOVE, 32'hDEAD_BEEF, 16'sh5, 16'sh5, 4'd0);
        send_beat(CMD_SPARE_LO, 32'h1234_5678, 16'sh7FFF, 16'sh8000, 4'd15);
        send_beat(CMD_SPARE_HI, 32'hFFFF_FFFF, 16'shFFFF, 16'shFFFF, 4'd9);
        // position extremes on the id extremes
        send_beat(CMD_DOWN, 32'h0, 16'sh8000, 16'sh7FFF, 4'd0);
        send_beat(CMD_DOWN, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 4'd0);
        send_beat(CMD_QUERY, 32'h0, 16'sh0, 16'sh0, 4'd1);
        send_beat(CMD_MOVE, 32'h0, 16'sh1, 16'shFFFF, 4'd0);
        // end a contact, query past it, then reuse its ended entry
        send_beat(CMD_UP, 32'hFFFF_FFFF, 16'sh0, 16'sh0, 4'd0);
        send_beat(CMD_QUERY, 32'h0, 16'sh0, 16'sh0, 4'd1);
        send_beat(CMD_DOWN, 32'hFFFF_FFFF, 16'sh007B, 16'shFE38, 4'd0);
        send_beat(CMD_QUERY, 32'h0, 16'sh0, 16'sh0, 4'd15);
        // fill the table, last down overflows
        for (k = 0; k < MAX_CONTACTS - 1; k++)
            send_beat(CMD_DOWN, 32'h1000_0000 + k, 16'(k), 16'(-k), 4'd0);

        // random: chunks with their own mix, pool size and idling style
        for (chunk = 0; chunk < CHUNKS; chunk++)
        begin
            kind = traffic_t'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0:       pool_used = 3;
                1:       pool_used = 12;
                2:       pool_used = 24;
                default: pool_used = POOL_SIZE;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            for (n = 0; n < CHUNK_BEATS; n++)
            begin
                q = $urandom_range(0, 1) ? QIDX_W'($urandom_range(0, 7))
                                         : QIDX_W'($urandom_range(0, 15));
                send_beat(pick_cmd(kind), pick_id(pool_used), 16'($urandom), 16'($urandom), q);
            end
        end
        evt_ch.valid <= 1'b0;

        // drain, then a tail for anything stray
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && results_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
